>>> hw/rtl/plact_pkg.sv
// ----------------------------------------------------------------------------
// plact_pkg - shared definitions for the piecewise-linear activation
// Register codes, default widths, table sizes and status types.
// ----------------------------------------------------------------------------
package plact_pkg;

	localparam int DATA_WIDTH_DEF = 32;
	localparam int FRAC_BITS_DEF  = 16;
	localparam int MAX_VERTICES   = 3;
	localparam int NUM_VERT       = 3;
	localparam int NUM_SEG        = 4;
	localparam int FIFO_DEPTH     = 4;
	localparam int CFG_IDX_W      = 3;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_THRESH_VALUE   = 3'd0,
		REG_WIDTH_VALUE    = 3'd1,
		REG_SHIFT_VALUE    = 3'd2,
		REG_FLOOR_VALUE    = 3'd3,
		REG_CEILING_VALUE  = 3'd4,
		REG_THRESH_ENABLE  = 3'd5,
		REG_CEILING_ENABLE = 3'd6
	} cfg_reg_t;

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_LOAD = 3'b010,
		ST_DIV  = 3'b100
	} tbl_state_t;

	typedef struct packed {
		logic       busy;
		logic [1:0] vcount;
	} tbl_stat_t;

endpackage

>>> hw/rtl/plact_tbl.sv
// ----------------------------------------------------------------------------
// plact_tbl - register file and vertex table builder
// Holds the registers, rebuilds vertices and segment slopes after each write;
// slopes come from a shared restoring divider, one quotient bit a cycle.
// ----------------------------------------------------------------------------
module plact_tbl import plact_pkg::*; #(
	parameter int DATA_WIDTH = DATA_WIDTH_DEF,
	parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic [CFG_IDX_W-1:0]         cfg_idx,
	input  logic [DATA_WIDTH-1:0]        cfg_wdata,
	output logic signed [DATA_WIDTH-1:0] vpot [NUM_VERT],
	output logic signed [DATA_WIDTH-1:0] vact [NUM_VERT],
	output logic signed [DATA_WIDTH-1:0] sslope [NUM_SEG],
	output tbl_stat_t                    stat
);

	localparam int DW = DATA_WIDTH;
	localparam int WW = DW + 2;
	localparam int NB = DW + 1 + FRAC_BITS;
	localparam int CW = $clog2(NB + 1);
	localparam logic signed [WW-1:0] WMAX = {3'b000, {(DW-1){1'b1}}};
	localparam logic signed [WW-1:0] WMIN = {3'b111, {(DW-1){1'b0}}};
	localparam logic signed [DW-1:0] DMAX = {1'b0, {(DW-1){1'b1}}};
	localparam logic signed [DW-1:0] DMIN = {1'b1, {(DW-1){1'b0}}};
	localparam logic signed [DW-1:0] ONE  = DW'(1) << FRAC_BITS;

	function automatic logic signed [WW-1:0] sat(input logic signed [WW-1:0] x);
		logic signed [WW-1:0] r;
		if (x > WMAX)
			r = WMAX;
		else if (x < WMIN)
			r = WMIN;
		else
			r = x;
		return r;
	endfunction

	logic signed [DW-1:0] thr_q, wid_q, shf_q, flr_q, cel_q;
	logic                 ten_q, cen_q;
	logic signed [DW-1:0] vpot_q [NUM_VERT];
	logic signed [DW-1:0] vact_q [NUM_VERT];
	logic signed [DW-1:0] slp_q  [NUM_SEG];
	logic [1:0]           vcnt_q;
	tbl_state_t           state_q;
	logic [1:0]           k_q;
	logic                 init_q;
	logic                 neg_q;
	logic [NB-1:0]        num_q;
	logic [DW:0]          den_q;
	logic [DW:0]          rem_q;
	logic [CW-1:0]        cnt_q;

	// combinational vertex build
	logic signed [WW-1:0] t, w, sh, fl, cl;
	logic signed [WW-1:0] bv [NUM_VERT];
	logic signed [WW-1:0] ba [NUM_VERT];
	logic [1:0]           bn;
	logic                 sneg_one;

	always_comb begin
		t  = WW'(thr_q);
		w  = WW'(wid_q);
		sh = WW'(shf_q);
		fl = WW'(flr_q);
		cl = WW'(cel_q);
		for (int i = 0; i < NUM_VERT; i++) begin
			bv[i] = '0;
			ba[i] = '0;
		end
		if (w < 0) begin
			t = sat(t + w);
			w = sat(-w);
		end
		if (!ten_q) begin
			bn       = 2'd1;
			ba[0]    = sat(-sh);
			sneg_one = 1'b1;
		end else begin
			sneg_one = 1'b0;
			bv[0]    = t;
			ba[0]    = fl;
			if (w == 0 && t - sh == fl) begin
				bn = 2'd1;
			end else begin
				bn    = 2'd2;
				bv[1] = sat(t + w);
				ba[1] = sat(t + w - sh);
			end
		end
		if (cen_q) begin
			if (ba[bn - 2'd1] < cl) begin
				if (bn < 2'(MAX_VERTICES)) begin
					bv[bn] = sat(bv[bn - 2'd1] + cl - ba[bn - 2'd1]);
					ba[bn] = cl;
					bn     = bn + 2'd1;
				end
			end else if (bn == 2'd2 && ba[0] < cl) begin
				// cut after the first vertex, ceiling vertex goes second
				bv[1] = sat(bv[0] + cl - ba[0]);
				ba[1] = cl;
			end else begin
				bn = 2'd1;
				if (sneg_one)
					bv[0] = sat(bv[0] - (ba[0] - cl));
				else
					bv[0] = '0;
				ba[0] = cl;
			end
		end
	end

	// divider operands from the stored table
	logic signed [DW:0] d_v, d_a;
	logic [DW:0]        mag_a, mag_v;
	logic [DW+1:0]      trial;
	logic [DW+1:0]      trial_sub;
	logic signed [DW-1:0] quo_sat;

	always_comb begin
		d_v       = (DW+1)'(vpot_q[k_q]) - (DW+1)'(vpot_q[k_q - 2'd1]);
		d_a       = (DW+1)'(vact_q[k_q]) - (DW+1)'(vact_q[k_q - 2'd1]);
		mag_a     = d_a < 0 ? (DW+1)'(-d_a) : (DW+1)'(d_a);
		mag_v     = d_v < 0 ? (DW+1)'(-d_v) : (DW+1)'(d_v);
		trial     = {rem_q, num_q[NB-1]};
		trial_sub = trial - {1'b0, den_q};
		if (!neg_q)
			quo_sat = (num_q > NB'(DMAX)) ? DMAX : DW'(num_q);
		else
			quo_sat = (num_q > (NB'(1) << (DW-1))) ? DMIN : DW'(-num_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q   <= '0;
			wid_q   <= '0;
			shf_q   <= '0;
			flr_q   <= '0;
			cel_q   <= '0;
			ten_q   <= 1'b0;
			cen_q   <= 1'b0;
			for (int i = 0; i < NUM_VERT; i++) begin
				vpot_q[i] <= '0;
				vact_q[i] <= '0;
			end
			slp_q[0] <= ONE;
			slp_q[1] <= ONE;
			slp_q[2] <= '0;
			slp_q[3] <= '0;
			vcnt_q  <= 2'd1;
			state_q <= ST_IDLE;
			k_q     <= 2'd1;
			init_q  <= 1'b0;
			neg_q   <= 1'b0;
			num_q   <= '0;
			den_q   <= '0;
			rem_q   <= '0;
			cnt_q   <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
				end
				ST_LOAD: begin
					for (int i = 0; i < NUM_VERT; i++) begin
						vpot_q[i] <= (2'(i) < bn) ? DW'(bv[i]) : '0;
						vact_q[i] <= (2'(i) < bn) ? DW'(ba[i]) : '0;
					end
					for (int i = 1; i < NUM_SEG; i++)
						slp_q[i] <= (2'(i) == bn && !cen_q) ? ONE : '0;
					slp_q[0] <= sneg_one ? ONE : '0;
					vcnt_q   <= bn;
					k_q      <= 2'd1;
					init_q   <= 1'b1;
					state_q  <= (bn == 2'd1) ? ST_IDLE : ST_DIV;
				end
				ST_DIV: begin
					if (init_q) begin
						init_q <= 1'b0;
						if (d_v == 0) begin
							slp_q[k_q] <= (d_a > 0) ? DMAX : ((d_a < 0) ? DMIN : '0);
							den_q      <= '0;
							cnt_q      <= '0;
						end else begin
							neg_q <= (d_a < 0) ^ (d_v < 0);
							num_q <= NB'(mag_a) << FRAC_BITS;
							den_q <= mag_v;
							rem_q <= '0;
							cnt_q <= CW'(NB);
						end
					end else if (cnt_q != '0) begin
						if (!trial_sub[DW+1]) begin
							rem_q <= trial_sub[DW:0];
							num_q <= {num_q[NB-2:0], 1'b1};
						end else begin
							rem_q <= trial[DW:0];
							num_q <= {num_q[NB-2:0], 1'b0};
						end
						cnt_q <= cnt_q - CW'(1);
						// finish the zero-divisor case is taken above
					end else begin
						// den_q is clear only when the zero-divisor arm wrote the slope
						if (den_q != '0)
							slp_q[k_q] <= quo_sat;
						if (k_q == vcnt_q - 2'd1) begin
							state_q <= ST_IDLE;
						end else begin
							k_q    <= k_q + 2'd1;
							init_q <= 1'b1;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
			if (cfg_we) begin
				case (cfg_idx)
					REG_THRESH_VALUE:   thr_q <= cfg_wdata;
					REG_WIDTH_VALUE:    wid_q <= cfg_wdata;
					REG_SHIFT_VALUE:    shf_q <= cfg_wdata;
					REG_FLOOR_VALUE:    flr_q <= cfg_wdata;
					REG_CEILING_VALUE:  cel_q <= cfg_wdata;
					REG_THRESH_ENABLE:  ten_q <= cfg_wdata[0];
					REG_CEILING_ENABLE: cen_q <= cfg_wdata[0];
					default: ;
				endcase
				if (cfg_idx <= REG_CEILING_ENABLE)
					state_q <= ST_LOAD;
			end
		end
	end

	assign vpot = vpot_q;
	assign vact = vact_q;
	assign sslope = slp_q;
	assign stat.busy   = (state_q != ST_IDLE);
	assign stat.vcount = vcnt_q;

endmodule

>>> hw/rtl/plact_front.sv
// ----------------------------------------------------------------------------
// plact_front - input side
// Takes potentials and picks the segment: base activity, slope, offset.
// ----------------------------------------------------------------------------
module plact_front import plact_pkg::*; #(
	parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic signed [DATA_WIDTH-1:0] pot,
	input  logic signed [DATA_WIDTH-1:0] vpot [NUM_VERT],
	input  logic signed [DATA_WIDTH-1:0] vact [NUM_VERT],
	input  logic signed [DATA_WIDTH-1:0] sslope [NUM_SEG],
	input  tbl_stat_t                    stat,
	input  logic                         q_full,
	output logic                         push,
	output logic [3*DATA_WIDTH:0]        push_data
);

	localparam int DW = DATA_WIDTH;

	logic [1:0]           last;
	logic signed [DW-1:0] sl, ba;
	logic signed [DW:0]   df;
	logic                 stop;

	always_comb begin
		last = (stat.vcount == 2'd0) ? 2'd0 : stat.vcount - 2'd1;
		sl   = '0;
		ba   = '0;
		df   = '0;
		stop = 1'b0;
		if (pot < vpot[0]) begin
			sl = sslope[0];
			ba = vact[0];
			df = (DW+1)'(pot) - (DW+1)'(vpot[0]);
		end else if (pot >= vpot[last]) begin
			sl = sslope[last + 2'd1];
			ba = vact[last];
			df = (DW+1)'(pot) - (DW+1)'(vpot[last]);
		end else begin
			for (int v = 0; v < NUM_VERT - 1; v++) begin
				if (2'(v) < last && !stop) begin
					if (pot < vpot[v]) begin
						stop = 1'b1;
					end else if (pot == vpot[v]) begin
						// on a vertex other than the last: its activity, flat slope
						sl = '0;
						ba = vact[v];
						df = '0;
					end else if (pot < vpot[v+1]) begin
						sl = sslope[v+1];
						ba = vact[v];
						df = (DW+1)'(pot) - (DW+1)'(vpot[v]);
					end
				end
			end
		end
	end

	assign in_ready  = !stat.busy && !q_full;
	assign push      = in_valid && in_ready;
	assign push_data = {df, ba, sl};

endmodule

>>> hw/rtl/plact_fifo.sv
// ----------------------------------------------------------------------------
// plact_fifo - small queue between front and back
// Register-based, first word fall-through.
// ----------------------------------------------------------------------------
module plact_fifo import plact_pkg::*; #(
	parameter int WIDTH = 8,
	parameter int DEPTH = FIFO_DEPTH
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wdata,
	output logic             full,
	input  logic             pop,
	output logic             nempty,
	output logic [WIDTH-1:0] rdata
);

	localparam int AW = $clog2(DEPTH);
	localparam int NW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [AW-1:0]    wp_q, rp_q;
	logic [NW-1:0]    cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push)
				wp_q <= (wp_q == AW'(DEPTH - 1)) ? '0 : wp_q + AW'(1);
			if (pop)
				rp_q <= (rp_q == AW'(DEPTH - 1)) ? '0 : rp_q + AW'(1);
			if (push && !pop)
				cnt_q <= cnt_q + NW'(1);
			else if (pop && !push)
				cnt_q <= cnt_q - NW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wp_q] <= wdata;
	end

	assign full   = (cnt_q == NW'(DEPTH));
	assign nempty = (cnt_q != '0);
	assign rdata  = mem_q[rp_q];

endmodule

>>> hw/rtl/plact_back.sv
// ----------------------------------------------------------------------------
// plact_back - output side
// Multiply slope by offset, scale, add base, saturate, hold for receiver.
// ----------------------------------------------------------------------------
module plact_back import plact_pkg::*; #(
	parameter int DATA_WIDTH = DATA_WIDTH_DEF,
	parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  q_nempty,
	input  logic [3*DATA_WIDTH:0] q_data,
	output logic                  pop,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [DATA_WIDTH-1:0] act,
	output logic [DATA_WIDTH-1:0] slope
);

	localparam int DW = DATA_WIDTH;
	localparam int PW = 2*DW + 1;
	localparam int SW = PW + 1;
	localparam logic signed [SW-1:0] SMAX = SW'({1'b0, {(DW-1){1'b1}}});
	localparam logic signed [SW-1:0] SMIN = -SMAX - SW'(1);

	logic signed [DW-1:0] q_sl, q_ba;
	logic signed [DW:0]   q_df;
	logic                 v_s1;
	logic signed [PW-1:0] prod_s1;
	logic signed [DW-1:0] ba_s1, sl_s1;
	logic                 vld_q;
	logic [DW-1:0]        act_q, slope_q;
	logic                 adv_out, adv_s1;
	logic signed [PW-1:0] biased, scaled;
	logic signed [SW-1:0] sum;

	assign q_sl = q_data[DW-1:0];
	assign q_ba = q_data[2*DW-1:DW];
	assign q_df = q_data[3*DW:2*DW];

	assign adv_out = !vld_q || out_ready;
	assign adv_s1  = !v_s1 || adv_out;
	assign pop     = q_nempty && adv_s1;

	always_comb begin
		// divide by one, truncating toward zero
		biased = prod_s1 + ((prod_s1 < 0) ? ((PW'(1) << FRAC_BITS) - PW'(1)) : '0);
		scaled = biased >>> FRAC_BITS;
		sum    = SW'(scaled) + SW'(ba_s1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1  <= 1'b0;
			vld_q <= 1'b0;
		end else begin
			if (adv_s1)
				v_s1 <= q_nempty;
			if (adv_out)
				vld_q <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			prod_s1 <= PW'(q_sl) * PW'(q_df);
			ba_s1   <= q_ba;
			sl_s1   <= q_sl;
		end
		if (adv_out && v_s1) begin
			act_q   <= (sum > SMAX) ? DW'(SMAX) : ((sum < SMIN) ? DW'(SMIN) : DW'(sum));
			slope_q <= sl_s1;
		end
	end

	assign out_valid = vld_q;
	assign act       = act_q;
	assign slope     = slope_q;

endmodule

>>> hw/rtl/piecewise_linear_activation.sv
// ----------------------------------------------------------------------------
// piecewise_linear_activation - fixed-point piecewise-linear transfer function
// Maps a signed potential to an activity and a slope.
// ----------------------------------------------------------------------------
// Use: write registers on the cfg channel (index, data; cfg_ready is always
// high). After each write the vertex table is rebuilt; s_tready is low until
// done, which rests on the shared bit-serial slope divider (two slopes at
// most).
// Potentials enter on s_* (one word per cycle when the table is settled and
// the queue has room); each word gives one result word on m_*: activity low,
// slope above. From accept to m_tvalid a word passes the queue (which falls
// through), the multiply stage and the output register. Throughput: one word
// per cycle while m_tready is high, set by the single multiplier stage.
// A stalled receiver holds the output register; the back end stops and the
// four-deep queue fills, then s_tready drops.
// Reset: registers zero, table is the identity, queue and pipeline empty;
// no rebuild is needed after reset.
// ----------------------------------------------------------------------------
module piecewise_linear_activation import plact_pkg::*; #(
	parameter int DATA_WIDTH = DATA_WIDTH_DEF,
	parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 s_tvalid,
	output logic                                 s_tready,
	input  logic [((DATA_WIDTH+7)/8)*8-1:0]      s_tdata,  // potential
	output logic                                 m_tvalid,
	input  logic                                 m_tready,
	output logic [((2*DATA_WIDTH+7)/8)*8-1:0]    m_tdata,  // activity, slope
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [CFG_IDX_W-1:0]                 cfg_index,
	input  logic [DATA_WIDTH-1:0]                cfg_data
);

	localparam int DW  = DATA_WIDTH;
	localparam int QW  = 3*DW + 1;
	localparam int TOW = ((2*DW+7)/8)*8;

	logic signed [DW-1:0] vpot   [NUM_VERT];
	logic signed [DW-1:0] vact   [NUM_VERT];
	logic signed [DW-1:0] sslope [NUM_SEG];
	tbl_stat_t            stat;
	logic                 q_full, q_push, q_pop, q_nempty;
	logic [QW-1:0]        q_wdata, q_rdata;
	logic [DW-1:0]        act, slope;
	logic                 cfg_we;

	assign cfg_ready = 1'b1;
	assign cfg_we    = cfg_valid && cfg_ready;

	plact_tbl #(.DATA_WIDTH(DATA_WIDTH), .FRAC_BITS(FRAC_BITS)) u_tbl (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_idx(cfg_index), .cfg_wdata(cfg_data),
		.vpot(vpot), .vact(vact), .sslope(sslope), .stat(stat)
	);

	plact_front #(.DATA_WIDTH(DATA_WIDTH)) u_front (
		.in_valid(s_tvalid), .in_ready(s_tready), .pot(s_tdata[DW-1:0]),
		.vpot(vpot), .vact(vact), .sslope(sslope), .stat(stat),
		.q_full(q_full), .push(q_push), .push_data(q_wdata)
	);

	plact_fifo #(.WIDTH(QW), .DEPTH(FIFO_DEPTH)) u_fifo (
		.clk(clk), .arst_n(arst_n),
		.push(q_push), .wdata(q_wdata), .full(q_full),
		.pop(q_pop), .nempty(q_nempty), .rdata(q_rdata)
	);

	plact_back #(.DATA_WIDTH(DATA_WIDTH), .FRAC_BITS(FRAC_BITS)) u_back (
		.clk(clk), .arst_n(arst_n),
		.q_nempty(q_nempty), .q_data(q_rdata), .pop(q_pop),
		.out_valid(m_tvalid), .out_ready(m_tready), .act(act), .slope(slope)
	);

	assign m_tdata = TOW'({slope, act});

	// no word taken while the table is being rebuilt
	a_busy_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		stat.busy |-> !s_tready)
		else $error("word accepted during rebuild");

	// a register write always starts a rebuild
	a_cfg_rebuild: assert property (@(posedge clk) disable iff (!arst_n)
		(cfg_valid && cfg_index <= REG_CEILING_ENABLE) |=> stat.busy)
		else $error("write did not start rebuild");

	// table always holds at least one vertex
	a_vcount: assert property (@(posedge clk) disable iff (!arst_n)
		stat.vcount != 2'd0)
		else $error("empty vertex table");

endmodule

>>> bench/piecewise_linear_activation_test.sv
// ----------------------------------------------------------------------------
// piecewise_linear_activation_test - self-checking bench for the activation
// Drives potentials through the stream port under random gaps and stalls.
// Reprograms the registers between phases, and checks every activity/slope
// word against a fixed-point model of the transfer function kept here.
// ----------------------------------------------------------------------------
class activation_scoreboard;
	typedef struct {
		logic signed [31:0] pot;
		logic signed [31:0] act;
		logic signed [31:0] slope;
	} pl_word_t;

	localparam longint ONE_FX = 64'sd65536;
	localparam longint DMAX   = 64'sd2147483647;
	localparam longint DMIN   = -64'sd2147483648;

	longint thr, wid, shf, flr, ceil;
	bit     thr_en, ceil_en;
	longint vpot[3], vact[3], seg[4];
	int     nvert;
	pl_word_t pending[$];
	int     errors;

	function new();
		thr = 0; wid = 0; shf = 0; flr = 0; ceil = 0;
		thr_en = 0; ceil_en = 0;
		errors = 0;
		build_table();
	endfunction

	function longint sat(longint x);
		if (x > DMAX) return DMAX;
		if (x < DMIN) return DMIN;
		return x;
	endfunction

	function void write_reg(plact_pkg::cfg_reg_t idx, logic [31:0] val);
		longint s;
		s = longint'($signed(val));
		case (idx)
			plact_pkg::REG_THRESH_VALUE:   thr = s;
			plact_pkg::REG_WIDTH_VALUE:    wid = s;
			plact_pkg::REG_SHIFT_VALUE:    shf = s;
			plact_pkg::REG_FLOOR_VALUE:    flr = s;
			plact_pkg::REG_CEILING_VALUE:  ceil = s;
			plact_pkg::REG_THRESH_ENABLE:  thr_en = val[0];
			plact_pkg::REG_CEILING_ENABLE: ceil_en = val[0];
			default: return;
		endcase
		build_table();
	endfunction

	// vertex list and segment slopes from the current registers
	function void build_table();
		longint t, w, v_[3], a_[3], sneg, spos, dv, da;
		int n, k, v;
		t = thr; w = wid; spos = ONE_FX;
		for (k = 0; k < 3; k++) begin
			v_[k] = 0; a_[k] = 0;
		end
		if (w < 0) begin
			t = sat(t + w);
			w = sat(-w);
		end
		if (!thr_en) begin
			n = 1; a_[0] = sat(-shf); sneg = ONE_FX;
		end else begin
			v_[0] = t; a_[0] = flr;
			if (w == 0 && t - shf == flr) begin
				n = 1;
			end else begin
				n = 2;
				v_[1] = sat(t + w);
				a_[1] = sat(t + w - shf);
			end
			sneg = 0;
		end
		if (ceil_en) begin
			if (a_[n-1] < ceil) begin
				if (n < 3) begin
					v_[n] = sat(v_[n-1] + (ceil - a_[n-1]));
					a_[n] = ceil;
					n++;
				end
			end else begin
				for (v = n - 1; v >= 0; v--)
					if (a_[v] < ceil) break;
				if (v >= 0) begin
					n = v + 1;
					if (n < 3) begin
						v_[n] = sat(v_[v] + (ceil - a_[v]));
						a_[n] = ceil;
						n++;
					end
				end else begin
					n = 1;
					if (sneg > 0) begin
						v_[0] = sat(v_[0] - (a_[0] - ceil));
					end else begin
						v_[0] = 0;
						sneg = 0;
					end
					a_[0] = ceil;
				end
			end
			spos = 0;
		end
		for (k = 0; k < 4; k++) seg[k] = 0;
		for (k = 0; k < 3; k++) begin
			vpot[k] = (k < n) ? v_[k] : 0;
			vact[k] = (k < n) ? a_[k] : 0;
		end
		seg[0] = sneg;
		seg[n] = spos;
		for (k = 1; k < n; k++) begin
			dv = v_[k] - v_[k-1];
			da = a_[k] - a_[k-1];
			if (dv != 0) seg[k] = sat((da * ONE_FX) / dv);
			else seg[k] = da > 0 ? DMAX : (da < 0 ? DMIN : 0);
		end
		nvert = n;
	endfunction

	function void note_potential(logic [31:0] raw);
		longint p, act, slope;
		int last, v;
		pl_word_t w;
		p = longint'($signed(raw));
		last = nvert - 1;
		act = 0; slope = 0;
		if (p < vpot[0]) begin
			slope = seg[0];
			act = sat(vact[0] + (slope * (p - vpot[0])) / ONE_FX);
		end else if (p >= vpot[last]) begin
			slope = seg[last+1];
			act = sat(vact[last] + (slope * (p - vpot[last])) / ONE_FX);
		end else begin
			for (v = 0; v < last; v++) begin
				if (p < vpot[v]) break;
				if (p == vpot[v]) begin
					act = vact[v]; slope = 0;
				end else if (p < vpot[v+1]) begin
					slope = seg[v+1];
					act = sat(vact[v] + (slope * (p - vpot[v])) / ONE_FX);
				end
			end
		end
		w.pot = raw; w.act = act[31:0]; w.slope = slope[31:0];
		pending = {pending, w};
	endfunction

	function void check_word(logic [63:0] data, time now);
		pl_word_t w;
		if (pending.size() == 0) begin
			errors++;
			$display("%0t: unexpected result word %h", now, data);
			return;
		end
		w = pending.pop_front();
		if (data[31:0] !== w.act) begin
			errors++;
			$display("%0t: potential %0d activity expected %0d got %0d", now,
				w.pot, w.act, $signed(data[31:0]));
		end
		if (data[63:32] !== w.slope) begin
			errors++;
			$display("%0t: potential %0d slope expected %0d got %0d", now,
				w.pot, w.slope, $signed(data[63:32]));
		end
	endfunction
endclass

module piecewise_linear_activation_test;
	import plact_pkg::*;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [31:0] s_tdata;   // potential
	logic        m_tvalid;
	logic        m_tready;
	logic [63:0] m_tdata;   // activity, slope
	logic        cfg_valid;
	logic        cfg_ready;
	logic [2:0]  cfg_index;
	logic [31:0] cfg_data;

	activation_scoreboard sb;
	bit no_gaps;      // phase with back-to-back words on both sides
	bit long_hold;    // receiver holds off for a long stretch once

	piecewise_linear_activation dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	initial begin
		clk = 0;
		forever #6 clk = ~clk;
	end

	// watchdog
	initial begin
		#(12 * 600000);
		$display("FAIL piecewise_linear_activation");
		$finish;
	end

	// result side: random stalls, one long hold-off when asked
	initial begin
		int gap;
		m_tready = 0;
		forever begin
			@(negedge clk);
			if (long_hold) begin
				m_tready = 0;
				repeat (60) @(negedge clk);
				long_hold = 0;
			end
			gap = no_gaps ? 0 : $urandom_range(0, 3);
			if (gap > 0) begin
				m_tready = 0;
				repeat (gap) @(negedge clk);
			end
			m_tready = 1;
			do @(posedge clk); while (!(m_tvalid && arst_n));
		end
	end

	always @(posedge clk)
		if (arst_n && m_tvalid && m_tready) sb.check_word(m_tdata, $time);

	task automatic send_potential(logic [31:0] p);
		int gap;
		gap = no_gaps ? 0 : $urandom_range(0, 3);
		if (gap > 0) begin
			s_tvalid = 0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid = 1;
		s_tdata = p;
		do @(posedge clk); while (!s_tready);
		sb.note_potential(p);
		@(negedge clk);
	endtask

	task automatic write_reg(cfg_reg_t idx, logic [31:0] val);
		cfg_valid = 1;
		cfg_index = idx;
		cfg_data = val;
		do @(posedge clk); while (!cfg_ready);
		sb.write_reg(idx, val);
		@(negedge clk);
		cfg_valid = 0;
	endtask

	// every result in before touching the registers
	task automatic drain();
		s_tvalid = 0;
		while (sb.pending.size() != 0) @(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic program_all(logic [31:0] t, logic [31:0] w, logic [31:0] sh,
			logic [31:0] fl, logic [31:0] cl, bit te, bit ce);
		drain();
		write_reg(REG_THRESH_VALUE, t);
		write_reg(REG_WIDTH_VALUE, w);
		write_reg(REG_SHIFT_VALUE, sh);
		write_reg(REG_FLOOR_VALUE, fl);
		write_reg(REG_CEILING_VALUE, cl);
		write_reg(REG_THRESH_ENABLE, {31'b0, te});
		write_reg(REG_CEILING_ENABLE, {31'b0, ce});
		// table rebuild drops s_tready in the cycle after the write
		repeat (2) @(negedge clk);
	endtask

	// half near the vertices, the rest anywhere or at the extremes
	function automatic logic [31:0] pick_potential();
		int k;
		case ($urandom_range(0, 3))
			0: return $urandom;
			1: return 32'($urandom_range(0, 1) ? 32'h7fffffff - $urandom_range(0, 3)
				: 32'h80000000 + $urandom_range(0, 3));
			default: begin
				k = $urandom_range(0, sb.nvert - 1);
				return 32'(sb.vpot[k] + $signed($urandom_range(0, 16)) - 8
					+ ($urandom_range(0, 1) ? $signed($urandom_range(0, 1 << 20))
					- (1 << 19) : 0));
			end
		endcase
	endfunction

	function automatic logic [31:0] pick_value();
		case ($urandom_range(0, 4))
			0: return $urandom;
			1: return $urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000;
			default: return 32'($signed($urandom_range(0, 1 << 22)) - (1 << 21));
		endcase
	endfunction

	initial begin
		logic [31:0] t, sh, fl;
		sb = new();
		no_gaps = 0;
		long_hold = 0;
		arst_n = 0;
		s_tvalid = 0;
		s_tdata = 0;
		cfg_valid = 0;
		cfg_index = REG_THRESH_VALUE;
		cfg_data = 0;
		repeat (4) @(negedge clk);
		arst_n = 1;
		@(negedge clk);

		// identity after reset, extremes of the potential
		send_potential(32'h80000000);
		send_potential(32'h7fffffff);
		send_potential(32'h0);
		send_potential(32'hffffffff);
		send_potential(32'h00010000);

		// threshold ramp, on and around both vertices
		program_all(32'h00010000, 32'h00020000, 32'h00008000, 32'h0, 32'h0, 1, 0);
		send_potential(32'h00010000);
		send_potential(32'h0000ffff);
		send_potential(32'h00020000);
		send_potential(32'h00030000);
		send_potential(32'h00040000);
		// negative width folded, ceiling clips the ramp
		program_all(32'h00030000, 32'hfffe0000, 32'h0, 32'hffff0000, 32'h00018000,
			1, 1);
		send_potential(32'h00010000);
		send_potential(32'h00018000);
		send_potential(32'h7fffffff);
		// zero width whose vertex merges with the floor
		program_all(32'h00020000, 32'h0, 32'h00010000, 32'h00010000, 32'h0, 1, 0);
		send_potential(32'h00020000);
		send_potential(32'h0001ffff);
		send_potential(32'h00030000);
		// ceiling below all vertices: constant, and shifted identity
		program_all(32'h0, 32'h00010000, 32'h0, 32'h00050000, 32'h00010000, 1, 1);
		send_potential(32'h80000000);
		send_potential(32'h7fffffff);
		program_all(32'h0, 32'h0, 32'hfff00000, 32'h0, 32'h00010000, 0, 1);
		send_potential(32'h80000000);
		send_potential(32'h0);
		// saturating extremes, coincident vertices
		program_all(32'h7fffffff, 32'h7fffffff, 32'h80000000, 32'h80000000,
			32'h7fffffff, 1, 1);
		send_potential(32'h7fffffff);
		send_potential(32'h80000000);

		// random phases; long hold-off in the first so the queue backs up
		for (int ph = 0; ph < 24; ph++) begin
			t = pick_value();
			sh = pick_value();
			fl = $urandom_range(0, 3) == 0 ? 32'(t - sh) : pick_value();
			program_all(t, $urandom_range(0, 3) == 0 ? 32'h0 : pick_value(), sh, fl,
				pick_value(), $urandom_range(0, 3) != 0, $urandom_range(0, 1));
			no_gaps = (ph % 5 == 2);
			if (ph == 0) long_hold = 1;
			for (int i = 0; i < 64; i++) send_potential(pick_potential());
			no_gaps = 0;
		end

		drain();
		repeat (10) @(negedge clk);
		if (sb.errors == 0) begin
			$display("PASS piecewise_linear_activation");
		end else begin
			$display("FAIL piecewise_linear_activation");
		end
		$finish;
	end
endmodule

>>> piecewise_linear_activation.f
hw/rtl/plact_pkg.sv
hw/rtl/plact_tbl.sv
hw/rtl/plact_front.sv
hw/rtl/plact_fifo.sv
hw/rtl/plact_back.sv
hw/rtl/piecewise_linear_activation.sv
bench/piecewise_linear_activation_test.sv
